/* hw/rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// assertion macros
// concurrent assertion wrappers, empty when synthesizing
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// property must hold at every clock edge outside reset
`define ASSERT_PROP(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");
// expression must never be true outside reset
`define ASSERT_NEVER(lbl, clk, rst, expr) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("forbidden condition seen");
`else
`define ASSERT_PROP(lbl, clk, rst, prop)
`define ASSERT_NEVER(lbl, clk, rst, expr)
`endif

`endif

/* hw/rtl/rrsp_pkg.sv */
// ----------------------------------------------------------------------------
// rrsp_pkg
// shared constants, codes and types of the relay route block
// ----------------------------------------------------------------------------
package rrsp_pkg;

   localparam int MAX_NODES  = 256;
   localparam int NODE_W     = $clog2(MAX_NODES);
   localparam int COUNT_W    = NODE_W + 1;
   localparam int ADDR_W     = 2 * NODE_W;
   localparam int ROUTE_W    = NODE_W + 1;
   localparam int CMD_W      = 2;
   localparam int BW_W       = 21;
   localparam int DIST_W     = 29;
   localparam int SIZE_W     = 32;
   localparam int TIME_W     = 41;
   localparam int HOP_W      = 9;
   localparam int DIV_CNT_W  = $clog2(SIZE_W);
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 9;

   localparam logic [BW_W-1:0]   BW_LIMIT   = BW_W'(1048576);
   localparam logic [SIZE_W-1:0] COST_SCALE = SIZE_W'(1048576);

   typedef enum logic [CMD_W-1:0] {
      CMD_CLEAR,
      CMD_LOAD,
      CMD_COMPUTE,
      CMD_QUERY
   } cmd_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_NODE_COUNT,
      CSR_RELAY_NODE
   } csr_idx_type;

   typedef enum logic [4:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LD_RD,
      ST_LD_CMP,
      ST_LD_DIV,
      ST_LD_WR,
      ST_CP_ROW,
      ST_CP_INIT,
      ST_CP_SCAN,
      ST_CP_PICK,
      ST_CP_DECIDE,
      ST_CP_RELAX,
      ST_CP_RDRAIN,
      ST_Q_CHK1,
      ST_Q_CHK2,
      ST_Q_CHK3,
      ST_W_TEST,
      ST_W_PAR,
      ST_W_BW,
      ST_W_DIV,
      ST_Q_OUT
   } state_type;

endpackage

/* hw/rtl/rrsp_intf.sv */
// ----------------------------------------------------------------------------
// rrsp channel interfaces
// request, response and register write channels with valid/ready
// ----------------------------------------------------------------------------
interface rrsp_req_if;
   import rrsp_pkg::*;
   logic                valid;
   logic                ready;
   logic [CMD_W-1:0]    command;
   logic [NODE_W-1:0]   edge_from;
   logic [NODE_W-1:0]   edge_to;
   logic [BW_W-1:0]     edge_bandwidth;
   logic [NODE_W-1:0]   query_source;
   logic [NODE_W-1:0]   query_dest;
   logic [SIZE_W-1:0]   transfer_size;

   modport source (output valid, command, edge_from, edge_to, edge_bandwidth,
                   query_source, query_dest, transfer_size, input ready);
   modport sink (input valid, command, edge_from, edge_to, edge_bandwidth,
                 query_source, query_dest, transfer_size, output ready);
endinterface

interface rrsp_rsp_if;
   import rrsp_pkg::*;
   logic                valid;
   logic                ready;
   logic [HOP_W-1:0]    hop_count;
   logic [TIME_W-1:0]   transfer_time;

   modport source (output valid, hop_count, transfer_time, input ready);
   modport sink (input valid, hop_count, transfer_time, output ready);
endinterface

interface rrsp_csr_if;
   import rrsp_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

/* hw/rtl/rrsp_ram.sv */
// ----------------------------------------------------------------------------
// rrsp_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module rrsp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* hw/rtl/relay_route_shortest_path.sv */
// ----------------------------------------------------------------------------
// relay_route_shortest_path
// bandwidth graph store, all-source shortest path search and relay queries
// ----------------------------------------------------------------------------
// usage
//   req_ch  : commands clear / load edge / compute / query, one transfer each
//   rsp_ch  : one transfer per query with hop_count and transfer_time
//   csr_ch  : node_count and relay_node writes, always ready, write when idle
// one command at a time; req_ch.ready is high only while the sequencer idles
//   clear   : one bandwidth entry per cycle
//   load    : when the edge grows, cost = 2^20 / bandwidth through the shared
//             32-step restoring divider
//   compute : route-row clearing for every source row, plus for each source
//             below node_count an init step, then scan passes, each pass that
//             finds a node followed by a relax pass; each step is one ram read per cycle over the n nodes
//   query   : checks both legs, then walks the route node by node with a divide for every hop
// the divider gives one quotient bit per cycle; the rams have one read and one write port
// after reset a clearing pass empties the bandwidth store; no request is
// taken meanwhile, register writes still are
// a finished result sits in the output register until rsp_ch takes it; other
// commands run meanwhile, a second query waits for the register to empty
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module relay_route_shortest_path (
   input  logic        clock,
   input  logic        reset,
   rrsp_req_if.sink    req_ch,
   rrsp_rsp_if.source  rsp_ch,
   rrsp_csr_if.sink    csr_ch
);

   import rrsp_pkg::*;

   // sequencer and configuration
   state_type             state_ff, state_in;
   logic [COUNT_W-1:0]    node_count_ff, node_count_in;
   logic [NODE_W-1:0]     relay_ff, relay_in;
   logic [COUNT_W-1:0]    n_act;

   // latched request fields
   logic [NODE_W-1:0]     f_ff, f_in, t_ff, t_in;
   logic [BW_W-1:0]       bwin_ff, bwin_in;
   logic [NODE_W-1:0]     src_ff, src_in, dst_ff, dst_in;
   logic [SIZE_W-1:0]     size_ff, size_in;

   // sweep and search counters
   logic [ADDR_W-1:0]     sweep_ff, sweep_in;
   logic [NODE_W-1:0]     s_ff, s_in;
   logic [COUNT_W-1:0]    vcnt_ff, vcnt_in;
   logic [NODE_W-1:0]     vd_ff, vd_in;
   logic                  vd_valid_ff, vd_valid_in;
   logic                  cand_d_ff, cand_d_in;
   logic [MAX_NODES-1:0]  done_ff, done_in;
   logic [MAX_NODES-1:0]  rreach_ff, rreach_in;
   logic                  found_ff, found_in;
   logic [NODE_W-1:0]     best_ff, best_in;
   logic [DIST_W-1:0]     best_dist_ff, best_dist_in;

   // shared divider
   logic [SIZE_W-1:0]     div_q_ff, div_q_in;
   logic [BW_W:0]         div_r_ff, div_r_in;
   logic [BW_W-1:0]       div_d_ff, div_d_in;
   logic [DIV_CNT_W-1:0]  div_cnt_ff, div_cnt_in;
   logic [BW_W:0]         div_t;
   logic                  div_ge;
   logic [BW_W:0]         div_r_nx;
   logic [SIZE_W-1:0]     div_q_nx;
   logic                  div_last;

   // route walk
   logic                  p1ok_ff, p1ok_in, p2ok_ff, p2ok_in;
   logic                  part_ff, part_in;
   logic [NODE_W-1:0]     from_ff, from_in, cur_ff, cur_in, par_ff, par_in;
   logic [COUNT_W-1:0]    steps_ff, steps_in;
   logic [COUNT_W:0]      count_ff, count_in;
   logic [TIME_W-1:0]     total_ff, total_in;

   // result register
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [HOP_W-1:0]      rsp_hop_ff, rsp_hop_in;
   logic [TIME_W-1:0]     rsp_time_ff, rsp_time_in;

   // ram ports
   logic                  bw_we;
   logic [ADDR_W-1:0]     bw_waddr, bwc_raddr;
   logic [BW_W-1:0]       bw_wdata, bw_rd;
   logic                  cost_we;
   logic [BW_W-1:0]       cost_rd;
   logic                  rt_we;
   logic [ADDR_W-1:0]     rt_waddr, rt_raddr;
   logic [ROUTE_W-1:0]    rt_wdata, rt_rd;
   logic                  ds_we;
   logic [NODE_W-1:0]     ds_waddr, ds_raddr;
   logic [DIST_W-1:0]     ds_wdata, ds_rd;

   // decode helpers
   logic                  req_fire;
   logic                  ld_ok;
   logic                  v_last, row_last, s_in_range, s_last;
   logic                  walk_end, pair_on, out_free;
   logic [DIST_W-1:0]     nd;
   logic                  rlx_act, rlx_new, rlx_tie;
   logic                  scn_take;
   logic [COUNT_W:0]      hop_full;

   assign n_act = (node_count_ff > COUNT_W'(MAX_NODES)) ? COUNT_W'(MAX_NODES)
                                                        : node_count_ff;

   assign req_ch.ready  = (state_ff == ST_IDLE);
   assign req_fire      = req_ch.valid && req_ch.ready;
   assign csr_ch.ready  = 1'b1;

   assign ld_ok      = ({1'b0, f_ff} < n_act) && ({1'b0, t_ff} < n_act);
   assign v_last     = (vcnt_ff == n_act - COUNT_W'(1));
   assign row_last   = (vcnt_ff[NODE_W-1:0] == '1);
   assign s_in_range = ({1'b0, s_ff} < n_act);
   assign s_last     = (s_ff == '1);
   assign walk_end   = (cur_ff == from_ff) || (steps_ff == COUNT_W'(MAX_NODES));
   // the hop into the first node after the relay is dropped when the
   // source part is missing from the route
   assign pair_on    = (bw_rd != '0) && !(part_ff && !p1ok_ff && (par_ff == from_ff));
   assign out_free   = !rsp_valid_ff || rsp_ch.ready;

   // restoring divider, one quotient bit per cycle
   assign div_t    = {div_r_ff[BW_W-1:0], div_q_ff[SIZE_W-1]};
   assign div_ge   = (div_t >= {1'b0, div_d_ff});
   assign div_r_nx = div_ge ? (div_t - {1'b0, div_d_ff}) : div_t;
   assign div_q_nx = {div_q_ff[SIZE_W-2:0], div_ge};
   assign div_last = (div_cnt_ff == DIV_CNT_W'(SIZE_W - 1));

   // relax stage: data of node vd is back from the rams
   assign nd      = best_dist_ff + DIST_W'(cost_rd);
   assign rlx_act = vd_valid_ff && (bw_rd != '0) &&
                    ((state_ff == ST_CP_RELAX) || (state_ff == ST_CP_RDRAIN));
   assign rlx_new = rlx_act && (!rreach_ff[vd_ff] || (nd < ds_rd));
   assign rlx_tie = rlx_act && !rlx_new && (nd == ds_rd) &&
                    (best_ff < rt_rd[NODE_W-1:0]);

   // minimum scan stage, first strict minimum wins
   assign scn_take = vd_valid_ff && cand_d_ff &&
                     ((state_ff == ST_CP_SCAN) || (state_ff == ST_CP_PICK)) &&
                     (!found_ff || (ds_rd < best_dist_ff));

   assign hop_full = count_ff - (COUNT_W+1)'(2);

   // ------------------------------------------------------------------
   // next state
   // ------------------------------------------------------------------
   always_comb begin : next_state
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (sweep_ff == '1) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_fire) begin
               unique case (cmd_type'(req_ch.command))
                  CMD_CLEAR:   state_in = ST_CLEAR;
                  CMD_LOAD:    state_in = ST_LD_RD;
                  CMD_COMPUTE: state_in = ST_CP_ROW;
                  CMD_QUERY:   state_in = ST_Q_CHK1;
                  default:     state_in = ST_IDLE;
               endcase
            end
         end
         ST_LD_RD:     state_in = ld_ok ? ST_LD_CMP : ST_IDLE;
         ST_LD_CMP:    state_in = (bwin_ff > bw_rd) ? ST_LD_DIV : ST_IDLE;
         ST_LD_DIV:    state_in = div_last ? ST_LD_WR : ST_LD_DIV;
         ST_LD_WR:     state_in = ST_IDLE;
         ST_CP_ROW: begin
            if (row_last) begin
               if (s_in_range) state_in = ST_CP_INIT;
               else if (s_last) state_in = ST_IDLE;
            end
         end
         ST_CP_INIT:   state_in = ST_CP_SCAN;
         ST_CP_SCAN:   state_in = v_last ? ST_CP_PICK : ST_CP_SCAN;
         ST_CP_PICK:   state_in = ST_CP_DECIDE;
         ST_CP_DECIDE: begin
            if (found_ff) state_in = ST_CP_RELAX;
            else state_in = s_last ? ST_IDLE : ST_CP_ROW;
         end
         ST_CP_RELAX:  state_in = v_last ? ST_CP_RDRAIN : ST_CP_RELAX;
         ST_CP_RDRAIN: state_in = ST_CP_SCAN;
         ST_Q_CHK1:    state_in = ST_Q_CHK2;
         ST_Q_CHK2:    state_in = ST_Q_CHK3;
         ST_Q_CHK3:    state_in = (p1ok_ff || rt_rd[NODE_W]) ? ST_W_TEST : ST_Q_OUT;
         ST_W_TEST: begin
            if (walk_end) state_in = (!part_ff && p2ok_ff) ? ST_W_TEST : ST_Q_OUT;
            else state_in = ST_W_PAR;
         end
         ST_W_PAR:     state_in = ST_W_BW;
         ST_W_BW:      state_in = pair_on ? ST_W_DIV : ST_W_TEST;
         ST_W_DIV:     state_in = div_last ? ST_W_TEST : ST_W_DIV;
         ST_Q_OUT:     state_in = out_free ? ST_IDLE : ST_Q_OUT;
         default:      state_in = ST_IDLE;
      endcase
   end

   // ------------------------------------------------------------------
   // ram read addresses
   // ------------------------------------------------------------------
   always_comb begin : read_addr
      bwc_raddr = {best_ff, vcnt_ff[NODE_W-1:0]};
      rt_raddr  = {s_ff, vcnt_ff[NODE_W-1:0]};
      ds_raddr  = vcnt_ff[NODE_W-1:0];
      unique case (state_ff)
         ST_LD_RD:  bwc_raddr = {f_ff, t_ff};
         ST_Q_CHK1: rt_raddr  = {src_ff, relay_ff};
         ST_Q_CHK2: rt_raddr  = {relay_ff, dst_ff};
         ST_W_TEST: rt_raddr  = {from_ff, cur_ff};
         ST_W_PAR:  bwc_raddr = {rt_rd[NODE_W-1:0], cur_ff};
         default: begin
         end
      endcase
   end

   // ------------------------------------------------------------------
   // datapath and ram writes
   // ------------------------------------------------------------------
   always_comb begin : datapath
      node_count_in = node_count_ff;
      relay_in      = relay_ff;
      f_in          = f_ff;
      t_in          = t_ff;
      bwin_in       = bwin_ff;
      src_in        = src_ff;
      dst_in        = dst_ff;
      size_in       = size_ff;
      sweep_in      = sweep_ff;
      s_in          = s_ff;
      vcnt_in       = vcnt_ff;
      vd_in         = vcnt_ff[NODE_W-1:0];
      vd_valid_in   = 1'b0;
      cand_d_in     = !done_ff[vcnt_ff[NODE_W-1:0]] && rreach_ff[vcnt_ff[NODE_W-1:0]];
      done_in       = done_ff;
      rreach_in     = rreach_ff;
      found_in      = found_ff;
      best_in       = best_ff;
      best_dist_in  = best_dist_ff;
      div_q_in      = div_q_ff;
      div_r_in      = div_r_ff;
      div_d_in      = div_d_ff;
      div_cnt_in    = div_cnt_ff;
      p1ok_in       = p1ok_ff;
      p2ok_in       = p2ok_ff;
      part_in       = part_ff;
      from_in       = from_ff;
      cur_in        = cur_ff;
      par_in        = par_ff;
      steps_in      = steps_ff;
      count_in      = count_ff;
      total_in      = total_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ch.ready;
      rsp_hop_in    = rsp_hop_ff;
      rsp_time_in   = rsp_time_ff;
      bw_we         = 1'b0;
      bw_waddr      = {f_ff, t_ff};
      bw_wdata      = bwin_ff;
      cost_we       = 1'b0;
      rt_we         = 1'b0;
      rt_waddr      = {s_ff, vd_ff};
      rt_wdata      = {1'b1, best_ff};
      ds_we         = 1'b0;
      ds_waddr      = vd_ff;
      ds_wdata      = nd;

      if (csr_ch.valid) begin
         unique case (csr_idx_type'(csr_ch.index))
            CSR_NODE_COUNT: node_count_in = csr_ch.data[COUNT_W-1:0];
            CSR_RELAY_NODE: relay_in      = csr_ch.data[NODE_W-1:0];
            default: begin
            end
         endcase
      end

      unique case (state_ff)
         ST_CLEAR: begin
            bw_we    = 1'b1;
            bw_waddr = sweep_ff;
            bw_wdata = '0;
            sweep_in = sweep_ff + ADDR_W'(1);
         end
         ST_IDLE: begin
            f_in     = req_ch.edge_from;
            t_in     = req_ch.edge_to;
            bwin_in  = (req_ch.edge_bandwidth > BW_LIMIT) ? BW_LIMIT
                                                         : req_ch.edge_bandwidth;
            src_in   = req_ch.query_source;
            dst_in   = req_ch.query_dest;
            size_in  = req_ch.transfer_size;
            sweep_in = '0;
            s_in     = '0;
            vcnt_in  = '0;
         end
         ST_LD_CMP: begin
            if (bwin_ff > bw_rd) begin
               bw_we      = 1'b1;
               div_q_in   = COST_SCALE;
               div_r_in   = '0;
               div_d_in   = bwin_ff;
               div_cnt_in = '0;
            end
         end
         ST_LD_DIV, ST_W_DIV: begin
            div_q_in   = div_q_nx;
            div_r_in   = div_r_nx;
            div_cnt_in = div_cnt_ff + DIV_CNT_W'(1);
            if (state_ff == ST_W_DIV && div_last) begin
               total_in = total_ff + TIME_W'(div_q_nx);
               cur_in   = par_ff;
            end
         end
         ST_LD_WR: begin
            cost_we = 1'b1;
         end
         ST_CP_ROW: begin
            // wipe route row s, reach bits included
            rt_we    = 1'b1;
            rt_waddr = {s_ff, vcnt_ff[NODE_W-1:0]};
            rt_wdata = '0;
            vcnt_in  = vcnt_ff + COUNT_W'(1);
            if (row_last) begin
               vcnt_in = '0;
               if (!s_in_range && !s_last) s_in = s_ff + NODE_W'(1);
            end
         end
         ST_CP_INIT: begin
            rt_we          = 1'b1;
            rt_waddr       = {s_ff, s_ff};
            rt_wdata       = {1'b1, {NODE_W{1'b0}}};
            ds_we          = 1'b1;
            ds_waddr       = s_ff;
            ds_wdata       = '0;
            done_in        = '0;
            rreach_in      = '0;
            rreach_in[s_ff] = 1'b1;
            found_in       = 1'b0;
            vcnt_in        = '0;
         end
         ST_CP_SCAN, ST_CP_PICK: begin
            if (state_ff == ST_CP_SCAN) begin
               vd_valid_in = 1'b1;
               vcnt_in     = vcnt_ff + COUNT_W'(1);
            end
            if (scn_take) begin
               found_in     = 1'b1;
               best_in      = vd_ff;
               best_dist_in = ds_rd;
            end
         end
         ST_CP_DECIDE: begin
            vcnt_in = '0;
            if (found_ff) done_in[best_ff] = 1'b1;
            else if (!s_last) s_in = s_ff + NODE_W'(1);
         end
         ST_CP_RELAX, ST_CP_RDRAIN: begin
            if (state_ff == ST_CP_RELAX) begin
               vd_valid_in = 1'b1;
               vcnt_in     = vcnt_ff + COUNT_W'(1);
            end else begin
               vcnt_in  = '0;
               found_in = 1'b0;
            end
            if (rlx_new) begin
               ds_we            = 1'b1;
               rt_we            = 1'b1;
               rreach_in[vd_ff] = 1'b1;
            end else if (rlx_tie) begin
               rt_we = 1'b1;
            end
         end
         ST_Q_CHK2: begin
            p1ok_in = rt_rd[NODE_W];
         end
         ST_Q_CHK3: begin
            p2ok_in  = rt_rd[NODE_W];
            count_in = p1ok_ff ? (COUNT_W+1)'(1) : '0;
            total_in = '0;
            steps_in = '0;
            part_in  = !p1ok_ff;
            from_in  = p1ok_ff ? src_ff : relay_ff;
            cur_in   = p1ok_ff ? relay_ff : dst_ff;
         end
         ST_W_TEST: begin
            if (walk_end) begin
               if (!part_ff && p2ok_ff) begin
                  part_in  = 1'b1;
                  from_in  = relay_ff;
                  cur_in   = dst_ff;
                  steps_in = '0;
               end
            end else begin
               count_in = count_ff + (COUNT_W+1)'(1);
               steps_in = steps_ff + COUNT_W'(1);
            end
         end
         ST_W_PAR: begin
            par_in = rt_rd[NODE_W-1:0];
         end
         ST_W_BW: begin
            if (pair_on) begin
               div_q_in   = size_ff;
               div_r_in   = '0;
               div_d_in   = bw_rd;
               div_cnt_in = '0;
            end else begin
               cur_in = par_ff;
            end
         end
         ST_Q_OUT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_hop_in   = (count_ff >= (COUNT_W+1)'(2)) ? hop_full[HOP_W-1:0] : '0;
               rsp_time_in  = total_ff;
            end
         end
         default: begin
         end
      endcase
   end

   // ------------------------------------------------------------------
   // registers
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         sweep_ff      <= '0;
         node_count_ff <= COUNT_W'(1);
         relay_ff      <= '0;
         vd_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         sweep_ff      <= sweep_in;
         node_count_ff <= node_count_in;
         relay_ff      <= relay_in;
         vd_valid_ff   <= vd_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      f_ff         <= f_in;
      t_ff         <= t_in;
      bwin_ff      <= bwin_in;
      src_ff       <= src_in;
      dst_ff       <= dst_in;
      size_ff      <= size_in;
      s_ff         <= s_in;
      vcnt_ff      <= vcnt_in;
      vd_ff        <= vd_in;
      cand_d_ff    <= cand_d_in;
      done_ff      <= done_in;
      rreach_ff    <= rreach_in;
      found_ff     <= found_in;
      best_ff      <= best_in;
      best_dist_ff <= best_dist_in;
      div_q_ff     <= div_q_in;
      div_r_ff     <= div_r_in;
      div_d_ff     <= div_d_in;
      div_cnt_ff   <= div_cnt_in;
      p1ok_ff      <= p1ok_in;
      p2ok_ff      <= p2ok_in;
      part_ff      <= part_in;
      from_ff      <= from_in;
      cur_ff       <= cur_in;
      par_ff       <= par_in;
      steps_ff     <= steps_in;
      count_ff     <= count_in;
      total_ff     <= total_in;
      rsp_hop_ff   <= rsp_hop_in;
      rsp_time_ff  <= rsp_time_in;
   end

   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.hop_count     = rsp_hop_ff;
   assign rsp_ch.transfer_time = rsp_time_ff;

   // ------------------------------------------------------------------
   // memories
   // ------------------------------------------------------------------
   // largest bandwidth per ordered pair, zero means no edge
   rrsp_ram #(.WIDTH(BW_W), .DEPTH(MAX_NODES * MAX_NODES)) u_bw_ram (
      .clock   (clock),
      .wr_en   (bw_we),
      .wr_addr (bw_waddr),
      .wr_data (bw_wdata),
      .rd_addr (bwc_raddr),
      .rd_data (bw_rd)
   );

   // edge cost 2^20 / bandwidth, only read where the bandwidth is nonzero
   rrsp_ram #(.WIDTH(BW_W), .DEPTH(MAX_NODES * MAX_NODES)) u_cost_ram (
      .clock   (clock),
      .wr_en   (cost_we),
      .wr_addr ({f_ff, t_ff}),
      .wr_data (div_q_ff[BW_W-1:0]),
      .rd_addr (bwc_raddr),
      .rd_data (cost_rd)
   );

   // reach flag and parent per source and node
   rrsp_ram #(.WIDTH(ROUTE_W), .DEPTH(MAX_NODES * MAX_NODES)) u_route_ram (
      .clock   (clock),
      .wr_en   (rt_we),
      .wr_addr (rt_waddr),
      .wr_data (rt_wdata),
      .rd_addr (rt_raddr),
      .rd_data (rt_rd)
   );

   // distance of each node for the current source
   rrsp_ram #(.WIDTH(DIST_W), .DEPTH(MAX_NODES)) u_dist_ram (
      .clock   (clock),
      .wr_en   (ds_we),
      .wr_addr (ds_waddr),
      .wr_data (ds_wdata),
      .rd_addr (ds_raddr),
      .rd_data (ds_rd)
   );

   // ------------------------------------------------------------------
   // assertions
   // ------------------------------------------------------------------
   `ASSERT_PROP(a_div_nonzero, clock, reset, ((state_ff == ST_LD_DIV) || (state_ff == ST_W_DIV)) |-> (div_d_ff != '0))
   `ASSERT_PROP(a_out_hold, clock, reset, ((state_ff == ST_Q_OUT) && rsp_valid_ff && !rsp_ch.ready) |=> (state_ff == ST_Q_OUT))
   `ASSERT_PROP(a_relax_done, clock, reset, (state_ff == ST_CP_RELAX) |-> done_ff[best_ff])
   `ASSERT_PROP(a_walk_bound, clock, reset, (state_ff == ST_W_TEST) |-> (steps_ff <= COUNT_W'(MAX_NODES)))
   `ASSERT_NEVER(a_load_range, clock, reset, bw_we && (state_ff == ST_LD_CMP) && !ld_ok)

endmodule

/* verif/relay_route_shortest_path_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// relay_route_shortest_path_tb
// drives clear, load, compute and query commands with random idling on both
// channels, predicts every relay route in a behavioral graph model and checks
// each response transfer field by field
// ----------------------------------------------------------------------------
module relay_route_shortest_path_tb;
   import rrsp_pkg::*;

   typedef struct {
      cmd_type            command;
      logic [NODE_W-1:0]  edge_from;
      logic [NODE_W-1:0]  edge_to;
      logic [BW_W-1:0]    edge_bandwidth;
      logic [NODE_W-1:0]  query_source;
      logic [NODE_W-1:0]  query_dest;
      logic [SIZE_W-1:0]  transfer_size;
   } graph_cmd_type;

   typedef struct {
      logic [HOP_W-1:0]   hop_count;
      logic [TIME_W-1:0]  transfer_time;
   } route_result_type;

   logic clock;
   logic reset;

   rrsp_req_if req_ch ();
   rrsp_rsp_if rsp_ch ();
   rrsp_csr_if csr_ch ();

   relay_route_shortest_path u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   // commands waiting for the driver, routes waiting for the response side
   graph_cmd_type    pending_cmds[$];
   route_result_type expected_routes[$];
   int               error_count = 0;

   // graph model state
   logic [BW_W-1:0]     link_bw[MAX_NODES*MAX_NODES];
   logic [NODE_W-1:0]   route_parent[MAX_NODES*MAX_NODES];
   bit                  route_reached[MAX_NODES*MAX_NODES];
   int unsigned         model_node_count;
   int unsigned         model_relay;

   // clock: period 4 ns
   always begin
      clock = 1'b1;
      #2;
      clock = 1'b0;
      #2;
   end

   initial begin
      req_ch.valid          = 1'b0;
      req_ch.command        = CMD_CLEAR;
      req_ch.edge_from      = '0;
      req_ch.edge_to        = '0;
      req_ch.edge_bandwidth = '0;
      req_ch.query_source   = '0;
      req_ch.query_dest     = '0;
      req_ch.transfer_size  = '0;
      rsp_ch.ready          = 1'b0;
      csr_ch.valid          = 1'b0;
      csr_ch.index          = CSR_NODE_COUNT;
      csr_ch.data           = '0;
   end

   function automatic int unsigned active_nodes();
      return (model_node_count > MAX_NODES) ? MAX_NODES : model_node_count;
   endfunction

   // all-source shortest path search, lowest-index parent on equal cost
   function automatic void build_routes();
      int unsigned n;
      int unsigned dist_row[MAX_NODES];
      bit          done[MAX_NODES];
      int unsigned best;
      int unsigned cand;
      int unsigned idx;
      bit          found;
      n = active_nodes();
      for (int i = 0; i < MAX_NODES * MAX_NODES; i++) begin
         route_reached[i] = 1'b0;
         route_parent[i]  = '0;
      end
      for (int s = 0; s < n; s++) begin
         for (int v = 0; v < n; v++) begin
            dist_row[v] = 0;
            done[v] = 1'b0;
         end
         route_reached[s*MAX_NODES + s] = 1'b1;
         forever begin
            found = 1'b0;
            best  = 0;
            for (int v = 0; v < n; v++) begin
               if (!done[v] && route_reached[s*MAX_NODES + v] &&
                   (!found || dist_row[v] < dist_row[best])) begin
                  best  = v;
                  found = 1'b1;
               end
            end
            if (!found) break;
            done[best] = 1'b1;
            for (int v = 0; v < n; v++) begin
               if (link_bw[best*MAX_NODES + v] == 0) continue;
               cand = dist_row[best] + 32'd1048576 / link_bw[best*MAX_NODES + v];
               idx  = s*MAX_NODES + v;
               if (!route_reached[idx] || cand < dist_row[v]) begin
                  dist_row[v]       = cand;
                  route_parent[idx] = best[NODE_W-1:0];
                  route_reached[idx] = 1'b1;
               end else if (cand == dist_row[v] && best < route_parent[idx]) begin
                  route_parent[idx] = best[NODE_W-1:0];
               end
            end
         end
      end
   endfunction

   // appends the nodes after 'from' up to 'to' onto the route
   function automatic void append_leg(int unsigned from, int unsigned to,
                                      ref int unsigned route[2*MAX_NODES+1],
                                      ref int unsigned len);
      int unsigned back[MAX_NODES];
      int unsigned cnt;
      int unsigned cur;
      cnt = 0;
      cur = to;
      while (cur != from && cnt < MAX_NODES) begin
         back[cnt] = cur;
         cnt++;
         cur = route_parent[from*MAX_NODES + cur];
      end
      for (int k = cnt; k > 0; k--) begin
         route[len] = back[k-1];
         len++;
      end
   endfunction

   function automatic route_result_type relay_route(graph_cmd_type c);
      int unsigned      route[2*MAX_NODES+1];
      int unsigned      len;
      logic [63:0]      total;
      logic [BW_W-1:0]  bw;
      route_result_type res;
      len   = 0;
      total = '0;
      if (route_reached[c.query_source*MAX_NODES + model_relay]) begin
         route[0] = c.query_source;
         len = 1;
         append_leg(c.query_source, model_relay, route, len);
      end
      // then the second leg; alone and without the relay if the first is unreachable
      if (model_relay < MAX_NODES &&
          route_reached[model_relay*MAX_NODES + c.query_dest])
         append_leg(model_relay, c.query_dest, route, len);
      for (int k = 0; k + 1 < len; k++) begin
         bw = link_bw[route[k]*MAX_NODES + route[k+1]];
         if (bw != 0) total += 64'(c.transfer_size) / 64'(bw);
      end
      res.hop_count     = (len >= 2) ? HOP_W'(len - 2) : '0;
      res.transfer_time = total[TIME_W-1:0];
      return res;
   endfunction

   // model update for one accepted command
   function automatic void apply_command(graph_cmd_type c);
      logic [BW_W-1:0] bw;
      int unsigned     n;
      n = active_nodes();
      case (c.command)
         CMD_CLEAR: begin
            for (int i = 0; i < MAX_NODES * MAX_NODES; i++) link_bw[i] = '0;
         end
         CMD_LOAD: begin
            bw = (c.edge_bandwidth > BW_LIMIT) ? BW_LIMIT : c.edge_bandwidth;
            if (c.edge_from < n && c.edge_to < n &&
                bw > link_bw[c.edge_from*MAX_NODES + c.edge_to])
               link_bw[c.edge_from*MAX_NODES + c.edge_to] = bw;
         end
         CMD_COMPUTE: build_routes();
         CMD_QUERY:   expected_routes = {expected_routes, relay_route(c)};
      endcase
   endfunction

   function automatic int unsigned draw_gap(ref bit quiet);
      if ($urandom_range(0, 7) == 0) quiet = !quiet;
      return quiet ? 0 : $urandom_range(0, 19);
   endfunction

   // request driver
   graph_cmd_type drive_cmd;
   int unsigned   send_gap = 0;
   bit            send_quiet = 1'b0;
   bit            send_hold;

   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else begin
         send_hold = req_ch.valid;
         if (req_ch.valid && req_ch.ready) begin
            apply_command(drive_cmd);
            send_hold = 1'b0;
         end
         if (!send_hold) begin
            if (send_gap > 0) begin
               send_gap--;
            end else if (pending_cmds.size() > 0) begin
               drive_cmd = pending_cmds.pop_front();
               req_ch.command        <= drive_cmd.command;
               req_ch.edge_from      <= drive_cmd.edge_from;
               req_ch.edge_to        <= drive_cmd.edge_to;
               req_ch.edge_bandwidth <= drive_cmd.edge_bandwidth;
               req_ch.query_source   <= drive_cmd.query_source;
               req_ch.query_dest     <= drive_cmd.query_dest;
               req_ch.transfer_size  <= drive_cmd.transfer_size;
               send_hold = 1'b1;
               send_gap  = draw_gap(send_quiet);
            end
         end
         req_ch.valid <= send_hold;
      end
   end

   // response monitor with random backpressure
   int unsigned      take_gap = 0;
   bit               take_quiet = 1'b0;
   route_result_type want;

   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (expected_routes.size() == 0) begin
               $display("%0t: response transfer with none expected: hop %0d time %0d",
                        $time, rsp_ch.hop_count, rsp_ch.transfer_time);
               error_count++;
            end else begin
               want = expected_routes.pop_front();
               if (rsp_ch.hop_count !== want.hop_count) begin
                  $display("%0t: hop_count expected %0d actual %0d",
                           $time, want.hop_count, rsp_ch.hop_count);
                  error_count++;
               end
               if (rsp_ch.transfer_time !== want.transfer_time) begin
                  $display("%0t: transfer_time expected %0d actual %0d",
                           $time, want.transfer_time, rsp_ch.transfer_time);
                  error_count++;
               end
            end
            take_gap = draw_gap(take_quiet);
         end
         if (take_gap > 0) begin
            take_gap--;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   task automatic push_cmd(cmd_type cmd, int unsigned f, int unsigned t, int unsigned bw,
                           int unsigned src, int unsigned dst, int unsigned size);
      graph_cmd_type c;
      c.command        = cmd;
      c.edge_from      = NODE_W'(f);
      c.edge_to        = NODE_W'(t);
      c.edge_bandwidth = BW_W'(bw);
      c.query_source   = NODE_W'(src);
      c.query_dest     = NODE_W'(dst);
      c.transfer_size  = SIZE_W'(size);
      pending_cmds = {pending_cmds, c};
   endtask

   task automatic push_load(int unsigned f, int unsigned t, int unsigned bw);
      push_cmd(CMD_LOAD, f, t, bw, $urandom, $urandom, $urandom);
   endtask

   task automatic push_query(int unsigned src, int unsigned dst, int unsigned size);
      push_cmd(CMD_QUERY, $urandom, $urandom, $urandom, src, dst, size);
   endtask

   // sender pauses until all routes are back and the sequencer idles again
   task automatic drain();
      while (pending_cmds.size() != 0 || req_ch.valid || expected_routes.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
   endtask

   task automatic write_reg(csr_idx_type idx, int unsigned value);
      csr_ch.index <= idx;
      csr_ch.data  <= CSR_DATA_W'(value);
      csr_ch.valid <= 1'b1;
      @(posedge clock);
      while (!csr_ch.ready) @(posedge clock);
      csr_ch.valid <= 1'b0;
      if (idx == CSR_NODE_COUNT) model_node_count = value & 9'h1FF;
      else model_relay = value & 8'hFF;
      @(posedge clock);
   endtask

   // stimulus
   initial begin
      int unsigned n;
      int unsigned bw;
      int unsigned f;
      int unsigned t;
      for (int i = 0; i < MAX_NODES * MAX_NODES; i++) link_bw[i] = '0;
      model_node_count = 1;
      model_relay      = 0;
      reset = 1'b1;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // wait out the bandwidth clearing pass after reset
      drain();
      write_reg(CSR_NODE_COUNT, 4);
      write_reg(CSR_RELAY_NODE, 1);

      // directed: small graph, relay 1
      push_load(0, 1, 1000);
      push_load(1, 2, 21'h1FFFFF);        // oversized, clamps to the limit
      push_load(1, 2, 5);                 // smaller, kept at the old value
      push_load(2, 3, 0);                 // zero bandwidth, no effect
      push_load(2, 3, 1048576);
      push_load(0, 2, 500);
      push_load(3, 0, 1);
      push_load(1, 3, 1);
      push_load(0, 255, 10);              // endpoint out of range
      push_load(255, 0, 10);
      push_cmd(CMD_COMPUTE, 0, 0, 0, 0, 0, 0);
      push_query(0, 3, 32'hFFFF_FFFF);
      push_query(1, 1, 0);
      push_query(3, 2, 12345);
      push_query(2, 0, 7);
      push_query(0, 255, 99999);          // second leg unreachable
      push_query(255, 2, 88888);          // first leg unreachable
      push_load(2, 0, 65536);             // edge changed after compute
      push_query(2, 3, 1000000);
      push_cmd(CMD_CLEAR, 0, 0, 0, 0, 0, 0);
      push_query(0, 3, 32'hFFFF_FFFF);    // routes kept, hops now carry no time
      drain();

      // no nodes at all
      write_reg(CSR_NODE_COUNT, 0);
      write_reg(CSR_RELAY_NODE, 0);
      push_cmd(CMD_COMPUTE, 0, 0, 0, 0, 0, 0);
      push_query(0, 0, 500);
      drain();

      // count above the maximum acts as the full node set, relay at the top
      write_reg(CSR_NODE_COUNT, 511);
      write_reg(CSR_RELAY_NODE, 255);
      push_load(0, 128, 1);
      push_load(128, 255, 2048);
      push_load(200, 255, 1048576);
      push_load(255, 0, 300);
      push_load(255, 200, 1);
      push_cmd(CMD_COMPUTE, 0, 0, 0, 0, 0, 0);
      push_query(0, 200, 32'hFFFF_FFFF);
      push_query(255, 0, 4096);
      push_query(200, 128, 77);
      drain();

      // random rounds on small graphs
      for (int round = 0; round < 4; round++) begin
         n = $urandom_range(2, 8);
         write_reg(CSR_NODE_COUNT, n);
         write_reg(CSR_RELAY_NODE, $urandom_range(0, n + 1));
         push_cmd(CMD_CLEAR, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
         for (int i = 0; i < 12; i++) begin
            if ($urandom_range(0, 5) == 0) begin
               f = $urandom_range(0, 255);
               t = $urandom_range(0, 255);
            end else begin
               f = $urandom_range(0, n - 1);
               t = $urandom_range(0, n - 1);
            end
            // powers of two give exact costs and frequent ties
            case ($urandom_range(0, 3))
               0, 1: bw = 1 << $urandom_range(10, 20);
               2:    bw = $urandom_range(1, 1048576);
               default: bw = $urandom_range(0, 21'h1FFFFF);
            endcase
            push_load(f, t, bw);
         end
         push_cmd(CMD_COMPUTE, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
         for (int i = 0; i < 10; i++) begin
            if ($urandom_range(0, 7) == 0)
               push_load($urandom_range(0, n - 1), $urandom_range(0, n - 1),
                         $urandom_range(1, 1048576));
            else if ($urandom_range(0, 5) == 0)
               push_query($urandom_range(0, 255), $urandom_range(0, 255), $urandom);
            else
               push_query($urandom_range(0, n - 1), $urandom_range(0, n - 1), $urandom);
         end
         drain();
      end

      repeat (200) @(posedge clock);
      if (error_count == 0) begin
         $display("relay_route_shortest_path: match");
      end else begin
         $display("relay_route_shortest_path: mismatch");
      end
      $finish;
   end

   // run limit
   initial begin
      #60000000;
      $display("relay_route_shortest_path: mismatch");
      $finish;
   end

endmodule
